### sv/tsa_pkg.sv
// ----------------------------------------------------------------------------
// tsa_pkg
// Shared types and constants for the trip statistics accumulator: item
// structs, op codes, controller/datapath command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package tsa_pkg;

  // default counter widths
  localparam int DIST_BITS_DEF = 40;
  localparam int TIME_BITS_DEF = 32;

  // output field widths
  localparam int OUT_DIST_W = 40;
  localparam int OUT_TIME_W = 32;
  localparam int SPEED_W    = 8;
  localparam int MS_W       = 24;
  localparam int OP_W       = 2;

  // op codes
  localparam logic [OP_W-1:0] OP_UPDATE = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  // unit conversion constants
  localparam int MS_PER_S   = 1000;   // ms per second
  localparam int KMH_MS_DIV = 3600;   // km/h * ms / 3600 = metres
  localparam int MIN_MS     = 1000;   // shorter updates are ignored

  // constant divides by reciprocal multiplication
  // prod / 3600 = (((prod >> 4) * DIST_RECIP) >> 36), exact for prod < 2^32
  // ms / 1000   = (((ms >> 3) * SEC_RECIP) >> 28), exact for ms < 2^24
  localparam int PROD_W     = SPEED_W + MS_W;      // speed * ms
  localparam int QUO_W      = 21;                  // quotient bits for prod / 3600
  localparam int DIST_PRE   = 4;
  localparam int DIST_SHIFT = 36;
  localparam logic [28:0] DIST_RECIP = 29'd305419897;
  localparam int SEC_PRE    = 3;
  localparam int SEC_SHIFT  = 28;
  localparam logic [21:0] SEC_RECIP  = 22'd2147484;

  // serial divider for the average: one quotient bit per cycle
  localparam int AVG_STEPS  = SPEED_W + 1;         // 8 bits plus overflow bit
  localparam int AVG_CNT_W  = $clog2(AVG_STEPS);

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SPEED_W-1:0] veh_speed;
    logic [MS_W-1:0]    elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [OUT_DIST_W-1:0] odo_dist;
    logic [OUT_DIST_W-1:0] trip_m;
    logic [OUT_TIME_W-1:0] run_secs;
    logic [OUT_TIME_W-1:0] trip_time_s;
    logic [SPEED_W-1:0]    top_speed;
    logic [SPEED_W-1:0]    mean_speed;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic acc;
    logic clr;
    logic prep1;
    logic prep2;
    logic avg_step;
    logic avg_fin;
    logic snap;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic upd;
    logic clr;
  } sts_t;

endpackage

`default_nettype wire

### sv/tsa_dp.sv
// ----------------------------------------------------------------------------
// tsa_dp
// Datapath: input capture, product, reciprocal divides for distance and
// seconds, serial divider for average speed, saturating counters and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_dp #(
  parameter int DIST_BITS = tsa_pkg::DIST_BITS_DEF,
  parameter int TIME_BITS = tsa_pkg::TIME_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  tsa_pkg::in_item_t   in_data,
  input  tsa_pkg::cmd_t       cmd,
  output tsa_pkg::sts_t       sts,
  output tsa_pkg::out_item_t  out_data
);
  import tsa_pkg::*;

  // average divider widths: numerator 36*D + 5*T, divisor 10*T shifted by 8
  localparam int NUM_W = ((DIST_BITS + 6 > TIME_BITS + 3) ? DIST_BITS + 6 : TIME_BITS + 3) + 1;
  localparam int DEN_W = TIME_BITS + 12;
  localparam int CW    = (NUM_W > DEN_W) ? NUM_W : DEN_W;

  // reciprocal product widths
  localparam int DPRD_W = DIST_SHIFT + QUO_W;
  localparam int SPRD_W = SEC_SHIFT + QUO_W;

  // item class flags
  logic upd_r, clr_r;

  // captured item and constant-divide quotients
  logic [SPEED_W-1:0]   spd_r;
  logic [MS_W-1:0]      ms_r;
  logic [PROD_W-1:0]    pr_r;
  logic [QUO_W-1:0]     dq_r, sq_r;
  logic [DPRD_W-1:0]    dist_prod;
  logic [SPRD_W-1:0]    sec_prod;

  // architectural counters
  logic [DIST_BITS-1:0] odo_r, trip_r;
  logic [TIME_BITS-1:0] run_r, trip_s_r;
  logic [SPEED_W-1:0]   peak_r, mean_r;

  // average divider
  logic [CW-1:0]        num_r, dv_r, t5_r;
  logic [AVG_STEPS-1:0] aq_r;

  // result register
  out_item_t out_r;

  // saturating sums
  logic [DIST_BITS:0]   odo_sum, trip_sum;
  logic [TIME_BITS:0]   run_sum, trip_s_sum;
  logic [63:0]          odo_w, trip_w, run_w, trip_s_w;
  logic [SPEED_W-1:0]   avg_q;

  // distance and seconds by reciprocal multiplication
  assign dist_prod = DPRD_W'(pr_r[PROD_W-1:DIST_PRE]) * DPRD_W'(DIST_RECIP);
  assign sec_prod  = SPRD_W'(ms_r[MS_W-1:SEC_PRE]) * SPRD_W'(SEC_RECIP);

  assign odo_sum    = {1'b0, odo_r}    + (DIST_BITS+1)'(dq_r);
  assign trip_sum   = {1'b0, trip_r}   + (DIST_BITS+1)'(dq_r);
  assign run_sum    = {1'b0, run_r}    + (TIME_BITS+1)'(sq_r);
  assign trip_s_sum = {1'b0, trip_s_r} + (TIME_BITS+1)'(sq_r);

  // clamp quotient to the trip peak
  always_comb begin
    if (aq_r[AVG_STEPS-1]) begin
      avg_q = peak_r;
    end else if (aq_r[SPEED_W-1:0] > peak_r) begin
      avg_q = peak_r;
    end else begin
      avg_q = aq_r[SPEED_W-1:0];
    end
  end

  // widen to 64 then take the field width
  assign odo_w    = 64'(odo_r);
  assign trip_w   = 64'(trip_r);
  assign run_w    = 64'(run_r);
  assign trip_s_w = 64'(trip_s_r);

  assign sts.upd  = upd_r;
  assign sts.clr  = clr_r;
  assign out_data = out_r;

  // capture and constant divide
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      upd_r <= (in_data.op == OP_UPDATE) && (in_data.elapsed_ms >= MS_W'(MIN_MS)) &&
               (in_data.veh_speed != '0);
      clr_r <= (in_data.op == OP_CLEAR);
      spd_r <= in_data.veh_speed;
      ms_r  <= in_data.elapsed_ms;
      pr_r  <= PROD_W'(in_data.veh_speed) * PROD_W'(in_data.elapsed_ms);
    end else if (cmd.div_step) begin
      dq_r <= dist_prod[DPRD_W-1:DIST_SHIFT];
      sq_r <= sec_prod[SPRD_W-1:SEC_SHIFT];
    end
  end

  // average speed divider
  always_ff @(posedge clk) begin
    if (cmd.prep1) begin
      num_r <= (CW'(trip_r) << 5) + (CW'(trip_r) << 2);
      t5_r  <= (CW'(trip_s_r) << 2) + CW'(trip_s_r);
    end else if (cmd.prep2) begin
      num_r <= num_r + t5_r;
      dv_r  <= t5_r << (AVG_STEPS);
      aq_r  <= '0;
    end else if (cmd.avg_step) begin
      if (num_r >= dv_r) begin
        num_r <= num_r - dv_r;
        aq_r  <= {aq_r[AVG_STEPS-2:0], 1'b1};
      end else begin
        aq_r  <= {aq_r[AVG_STEPS-2:0], 1'b0};
      end
      dv_r <= dv_r >> 1;
    end
  end

  // trip counters, saturating
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      odo_r    <= '0;
      trip_r   <= '0;
      run_r    <= '0;
      trip_s_r <= '0;
      peak_r   <= '0;
      mean_r   <= '0;
    end else if (cmd.acc) begin
      odo_r    <= odo_sum[DIST_BITS]    ? '1 : odo_sum[DIST_BITS-1:0];
      trip_r   <= trip_sum[DIST_BITS]   ? '1 : trip_sum[DIST_BITS-1:0];
      run_r    <= run_sum[TIME_BITS]    ? '1 : run_sum[TIME_BITS-1:0];
      trip_s_r <= trip_s_sum[TIME_BITS] ? '1 : trip_s_sum[TIME_BITS-1:0];
      if (spd_r > peak_r) begin
        peak_r <= spd_r;
      end
    end else if (cmd.clr) begin
      trip_r   <= '0;
      run_r    <= '0;
      trip_s_r <= '0;
      peak_r   <= '0;
      mean_r   <= '0;
    end else if (cmd.avg_fin) begin
      if (trip_s_r != '0) begin
        mean_r <= avg_q;
      end
    end
  end

  // result snapshot
  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      out_r.odo_dist    <= odo_w[OUT_DIST_W-1:0];
      out_r.trip_m      <= trip_w[OUT_DIST_W-1:0];
      out_r.run_secs    <= run_w[OUT_TIME_W-1:0];
      out_r.trip_time_s <= trip_s_w[OUT_TIME_W-1:0];
      out_r.top_speed   <= peak_r;
      out_r.mean_speed  <= mean_r;
    end
  end

endmodule

`default_nettype wire

### sv/tsa_ctrl.sv
// ----------------------------------------------------------------------------
// tsa_ctrl
// Controller: sequences one item through capture, then for an update division,
// counter update and average computation, for a clear the trip clear, and hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tsa_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire             out_stall,
  input  tsa_pkg::sts_t   sts,
  output tsa_pkg::cmd_t   cmd
);
  import tsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_DIV,
    S_ACC,
    S_PREP1,
    S_PREP2,
    S_AVG,
    S_FIN,
    S_CLR,
    S_DONE
  } state_t;

  state_t               state_r;
  logic [AVG_CNT_W-1:0] cnt_r;
  logic                 out_valid_r;
  logic                 can_out;

  assign can_out   = !out_valid_r || !out_stall;
  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // command decode per state
  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.div_step = (state_r == S_DIV);
    cmd.acc      = (state_r == S_ACC);
    cmd.clr      = (state_r == S_CLR);
    cmd.prep1    = (state_r == S_PREP1);
    cmd.prep2    = (state_r == S_PREP2);
    cmd.avg_step = (state_r == S_AVG);
    cmd.avg_fin  = (state_r == S_FIN);
    cmd.snap     = (state_r == S_DONE) && can_out;
  end

  // state, step counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // result valid: raised at hand-off, dropped once taken
      if ((state_r == S_DONE) && can_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          priority if (sts.upd) begin
            state_r <= S_DIV;
          end else if (sts.clr) begin
            state_r <= S_CLR;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_DIV: begin
          state_r <= S_ACC;
        end
        S_ACC: begin
          state_r <= S_PREP1;
        end
        S_PREP1: begin
          state_r <= S_PREP2;
        end
        S_PREP2: begin
          cnt_r   <= '0;
          state_r <= S_AVG;
        end
        S_AVG: begin
          cnt_r <= cnt_r + AVG_CNT_W'(1);
          if (cnt_r == AVG_CNT_W'(AVG_STEPS - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          state_r <= S_DONE;
        end
        S_CLR: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (can_out) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/trip_statistics_accumulator_unit.sv
// ----------------------------------------------------------------------------
// trip_statistics_accumulator_unit
// Vehicle trip computer: odometer, trip distance, run times, peak and
// average speed, updated by one item at a time.
// ----------------------------------------------------------------------------
// update item: dispatch, constant divide, counter update, average preparation,
//   the 9-step average divider and finish, then result hand-off
// trip-clear item: dispatch, clear, hand-off; read item: dispatch, hand-off
// one item in flight at a time, the next accepted only after hand-off
// reset: rst_n synchronous, clears all counters, peak and average to zero
// ----------------------------------------------------------------------------
`default_nettype none

module trip_statistics_accumulator_unit #(
  parameter int DIST_BITS = tsa_pkg::DIST_BITS_DEF,
  parameter int TIME_BITS = tsa_pkg::TIME_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  tsa_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output tsa_pkg::out_item_t  out_data
);
  import tsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  tsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and state
  tsa_dp #(
    .DIST_BITS (DIST_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

### tb/trip_statistics_accumulator_unit_test.sv
// ----------------------------------------------------------------------------
// trip_statistics_accumulator_unit_test
// Self-checking bench for the trip statistics accumulator. A short table of
// directed items covers reset state, field extremes, ignored updates, trip
// clear and the average clamp. Mostly-update random traffic follows. Each result
// is checked against a typed table snapshot or an in-bench model of the counters,
// with random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module trip_statistics_accumulator_unit_test;
  import tsa_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;   // unused code, acts as a read
  localparam int RANDOM_ITEMS = 1630;
  localparam int DRAIN_CYCLES = 40;
  localparam int CALM_SPAN    = 150;              // items per window without waits

  localparam logic [63:0] DIST_TOP = 64'({DIST_BITS_DEF{1'b1}});
  localparam logic [63:0] TIME_TOP = 64'({TIME_BITS_DEF{1'b1}});

  // one stimulus row: the item, and a typed snapshot where it is obvious
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [SPEED_W-1:0] speed;
    logic [MS_W-1:0]    ms;
    logic               typed;
    out_item_t          snap;
  } plan_row_t;

  localparam int PLAN_LEN = 20;

  plan_row_t directed_plan [0:PLAN_LEN-1] = '{
    '{OP_READ,   8'd0,   24'd0,       1'b1, '0},
    '{OP_SPARE,  8'd255, 24'hFFFFFF,  1'b1, '0},
    '{OP_UPDATE, 8'd255, 24'd999,     1'b1, '0},
    '{OP_UPDATE, 8'd0,   24'hFFFFFF,  1'b1, '0},
    '{OP_UPDATE, 8'd255, 24'hFFFFFF,  1'b1,
      '{40'd1188386, 40'd1188386, 32'd16777, 32'd16777, 8'd255, 8'd255}},
    '{OP_CLEAR,  8'd0,   24'd0,       1'b1,
      '{40'd1188386, 40'd0, 32'd0, 32'd0, 8'd0, 8'd0}},
    '{OP_UPDATE, 8'd1,   24'd1000,    1'b1,
      '{40'd1188386, 40'd0, 32'd1, 32'd1, 8'd1, 8'd0}},
    '{OP_UPDATE, 8'd128, 24'd3600,    1'b0, '0},
    '{OP_UPDATE, 8'd200, 24'd999,     1'b0, '0},
    '{OP_UPDATE, 8'd0,   24'd5000,    1'b0, '0},
    '{OP_READ,   8'd0,   24'd0,       1'b0, '0},
    '{OP_CLEAR,  8'd170, 24'h555555,  1'b0, '0},
    '{OP_UPDATE, 8'd10,  24'd1999,    1'b0, '0},
    '{OP_UPDATE, 8'd85,  24'd1000,    1'b0, '0},
    '{OP_UPDATE, 8'd255, 24'd1000,    1'b0, '0},
    '{OP_UPDATE, 8'd3,   24'h800000,  1'b0, '0},
    '{OP_UPDATE, 8'd100, 24'h7FFFFF,  1'b0, '0},
    '{OP_SPARE,  8'd0,   24'd0,       1'b0, '0},
    '{OP_READ,   8'd255, 24'hFFFFFF,  1'b0, '0},
    '{OP_CLEAR,  8'd0,   24'd0,       1'b0, '0}
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // model of the counters
  logic [DIST_BITS_DEF-1:0] odo_m;
  logic [DIST_BITS_DEF-1:0] trip_dist_m;
  logic [TIME_BITS_DEF-1:0] run_s;
  logic [TIME_BITS_DEF-1:0] trip_s;
  logic [SPEED_W-1:0]       peak_kmh;
  logic [SPEED_W-1:0]       mean_kmh;

  out_item_t expected_snapshots[$];
  int        mismatch_count;

  trip_statistics_accumulator_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  // wait cycles per item, with stretches of none
  function automatic int draw_wait(int n);
    if ((n / CALM_SPAN) % 4 == 3) return 0;
    return $urandom_range(0, 4);
  endfunction

  function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] top);
    if (b > top - a) return top;
    return a + b;
  endfunction

  // apply one item to the model, return the snapshot after it
  function automatic out_item_t apply_trip_item(in_item_t it);
    logic [63:0]  metres;
    logic [63:0]  secs;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] quo;
    out_item_t    snap;
    unique case (it.op)
      OP_UPDATE: begin
        if (it.elapsed_ms >= MIN_MS && it.veh_speed != 0) begin
          metres = (64'(it.veh_speed) * 64'(it.elapsed_ms)) / KMH_MS_DIV;
          secs   = 64'(it.elapsed_ms) / MS_PER_S;
          odo_m       = DIST_BITS_DEF'(add_clamped(64'(odo_m), metres, DIST_TOP));
          trip_dist_m = DIST_BITS_DEF'(add_clamped(64'(trip_dist_m), metres, DIST_TOP));
          run_s       = TIME_BITS_DEF'(add_clamped(64'(run_s), secs, TIME_TOP));
          trip_s      = TIME_BITS_DEF'(add_clamped(64'(trip_s), secs, TIME_TOP));
          if (it.veh_speed > peak_kmh) peak_kmh = it.veh_speed;
          // rounded 3.6 * m / s, never above the peak
          if (trip_s != 0) begin
            num = 128'(trip_dist_m) * 36 + 128'(trip_s) * 5;
            den = 128'(trip_s) * 10;
            quo = num / den;
            mean_kmh = (quo > 128'(peak_kmh)) ? peak_kmh : quo[SPEED_W-1:0];
          end
        end
      end
      OP_CLEAR: begin
        trip_dist_m = '0;
        peak_kmh    = '0;
        mean_kmh    = '0;
        run_s       = '0;
        trip_s      = '0;
      end
      default: ;
    endcase
    snap.odo_dist    = OUT_DIST_W'(odo_m);
    snap.trip_m      = OUT_DIST_W'(trip_dist_m);
    snap.run_secs    = OUT_TIME_W'(run_s);
    snap.trip_time_s = OUT_TIME_W'(trip_s);
    snap.top_speed   = peak_kmh;
    snap.mean_speed  = mean_kmh;
    return snap;
  endfunction

  // random item: mostly driving updates, some trip clears and reads
  function automatic in_item_t draw_trip_item();
    in_item_t it;
    int       kind;
    int       span;
    kind = $urandom_range(0, 99);
    span = $urandom_range(0, 9);
    it.veh_speed  = SPEED_W'($urandom_range(0, 255));
    it.elapsed_ms = MS_W'($urandom);
    if (kind < 8) begin
      it.op = OP_CLEAR;
    end else if (kind < 16) begin
      it.op = ($urandom_range(0, 1) == 0) ? OP_READ : OP_SPARE;
    end else begin
      it.op = OP_UPDATE;
      if ($urandom_range(0, 19) == 0) it.veh_speed = '0;
      else it.veh_speed = SPEED_W'($urandom_range(1, 255));
      if (span == 0) it.elapsed_ms = MS_W'($urandom_range(0, 999));
      else if (span != 1) it.elapsed_ms = MS_W'($urandom_range(1000, 5000));
    end
    return it;
  endfunction

  task automatic log_miss(input string what, input logic [63:0] want,
                          input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic check_snapshot(input out_item_t got);
    out_item_t want;
    if (expected_snapshots.size() == 0) begin
      log_miss("unexpected result, odo_dist", '0, 64'(got.odo_dist));
      return;
    end
    want = expected_snapshots.pop_front();
    if (got.odo_dist !== want.odo_dist)
      log_miss("odo_dist", 64'(want.odo_dist), 64'(got.odo_dist));
    if (got.trip_m !== want.trip_m)
      log_miss("trip_m", 64'(want.trip_m), 64'(got.trip_m));
    if (got.run_secs !== want.run_secs)
      log_miss("run_secs", 64'(want.run_secs), 64'(got.run_secs));
    if (got.trip_time_s !== want.trip_time_s)
      log_miss("trip_time_s", 64'(want.trip_time_s), 64'(got.trip_time_s));
    if (got.top_speed !== want.top_speed)
      log_miss("top_speed", 64'(want.top_speed), 64'(got.top_speed));
    if (got.mean_speed !== want.mean_speed)
      log_miss("mean_speed", 64'(want.mean_speed), 64'(got.mean_speed));
  endtask

  // result side: check each item, then stall the next one a random time
  initial begin
    int hold;
    int seen;
    hold = 0;
    seen = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        check_snapshot(out_data);
        seen++;
        hold = draw_wait(seen);
        out_stall <= (hold > 0);
      end else if (rst_n && out_valid && out_stall) begin
        hold--;
        out_stall <= (hold > 0);
      end
    end
  end

  // reset, stimulus and end of run
  initial begin
    in_item_t  item;
    out_item_t snap;
    int        gap;
    int        total;
    mismatch_count = 0;
    odo_m       = '0;
    trip_dist_m = '0;
    run_s       = '0;
    trip_s      = '0;
    peak_kmh    = '0;
    mean_kmh    = '0;
    total       = PLAN_LEN + RANDOM_ITEMS;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < total; i++) begin
      if (i < PLAN_LEN) begin
        item.op         = directed_plan[i].op;
        item.veh_speed  = directed_plan[i].speed;
        item.elapsed_ms = directed_plan[i].ms;
      end else begin
        item = draw_trip_item();
      end
      // idle before the item, valid stays up when there is no gap
      gap = draw_wait(i);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= item;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      snap = apply_trip_item(item);
      if (i < PLAN_LEN && directed_plan[i].typed)
        expected_snapshots.push_back(directed_plan[i].snap);
      else
        expected_snapshots.push_back(snap);
    end
    in_valid <= 1'b0;

    // drain
    while (expected_snapshots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
